>>> rtl/core/ose_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ose_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 64;
    localparam int HALF_W      = DATA_W / 2;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int OP_W        = 4;
    localparam int STATUS_W    = 3;
    localparam int TGT_W       = 32;
    localparam int DEPTH_W     = 7;
    localparam int OUT_USED_W  = STATUS_W + 1 + TGT_W + 1 + DATA_W + DEPTH_W;
    localparam int OUT_W       = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_MOD   = 4'd5,
        OP_EQ    = 4'd6,
        OP_LT    = 4'd7,
        OP_GT    = 4'd8,
        OP_LE    = 4'd9,
        OP_GE    = 4'd10,
        OP_JUMP  = 4'd11,
        OP_JZ    = 4'd12,
        OP_PRINT = 4'd13
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_FATAL = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic start;
    } t_unit_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    typedef struct packed {
        t_status             status;
        logic                taken;
        logic [TGT_W-1:0]    target;
        logic                pvalid;
        logic [DATA_W-1:0]   pval;
        logic [CNT_W-1:0]    count;
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [DATA_W-1:0]   wr_data;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/operand_stack_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tvalid/tready  tdata                                       tuser
// s_axis    in   handshake      immediate[63:0]                             req_type[3:0]
// m_axis    out  handshake      status, branch_taken, branch_target,        -
//                               print_valid, print_value, depth
//
// One item at a time: accept, then the stack memory read and execute. Multiply adds
// a pass through the multiplier (four 32x32 partial products, registered, then
// accumulated); divide and modulo add a pass through the shared divider (one quotient
// bit per cycle). Reset clears the stack count, the state and the output valid; the
// stack memory is not cleared. A result waits in the output register while the next
// item is accepted; a new result waits in a hold register until the output frees up.

module operand_stack_evaluator (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire [ose_pkg::DATA_W-1:0]  s_axis_tdata,  // immediate[63:0]
    input  wire [ose_pkg::OP_W-1:0]    s_axis_tuser,  // req_type[3:0]
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    // status[2:0], branch_taken[3], branch_target[35:4], print_valid[36],
    // print_value[100:37], depth[107:101], zero[111:108]
    output logic [ose_pkg::OUT_W-1:0]  m_axis_tdata
);
    import ose_pkg::*;

    localparam int DEPTH_LSB = OUT_USED_W - DEPTH_W;
    localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};

    t_state             r_state;
    t_state             n_state;
    t_op                r_op;
    logic [DATA_W-1:0]  r_imm;
    logic [CNT_W-1:0]   r_count;
    logic [DATA_W-1:0]  r_mem [STACK_DEPTH];
    logic [DATA_W-1:0]  r_rd_a;
    logic [DATA_W-1:0]  r_rd_b;
    t_result            r_hold;
    logic               r_m_valid;
    logic [OUT_W-1:0]   r_m_data;

    logic [ADDR_W-1:0]  addr_a;
    logic [ADDR_W-1:0]  addr_b;
    logic [DATA_W-1:0]  mag_a;
    logic [DATA_W-1:0]  mag_b;
    logic               neg_res;
    logic [DATA_W-1:0]  sum;
    logic [DATA_W-1:0]  dif;
    logic [DATA_W-1:0]  bin_val;
    logic               bin_ovf;
    logic [DATA_W-1:0]  mul_lo;
    logic               mul_ovf;
    logic [DATA_W-1:0]  div_val;
    logic               div_ovf;

    t_unit_req          mul_req;
    t_unit_req          div_req;
    t_unit_sts          mul_sts;
    t_unit_sts          div_sts;
    logic [PROD_W-1:0]  mul_prod;
    logic [DATA_W-1:0]  div_quot;
    logic [DATA_W-1:0]  div_rem;

    t_result            res;
    logic               res_ready;
    logic               out_free;
    logic               commit;
    logic               accept;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign commit   = res_ready && out_free;

    assign addr_b = ADDR_W'(r_count - CNT_W'(1));
    assign addr_a = ADDR_W'(r_count - CNT_W'(2));

    always_ff @(posedge i_clk) begin
        if (commit && res.wr_en) begin
            r_mem[res.wr_addr] <= res.wr_data;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    ose_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mag_a),
        .i_b     (mag_b),
        .o_sts   (mul_sts),
        .o_prod  (mul_prod)
    );

    ose_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (mag_a),
        .i_divisor  (mag_b),
        .o_sts      (div_sts),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        mag_a   = r_rd_a[DATA_W-1] ? (~r_rd_a + 1'b1) : r_rd_a;
        mag_b   = r_rd_b[DATA_W-1] ? (~r_rd_b + 1'b1) : r_rd_b;
        neg_res = r_rd_a[DATA_W-1] ^ r_rd_b[DATA_W-1];
        sum     = r_rd_a + r_rd_b;
        dif     = r_rd_a - r_rd_b;
    end

    always_comb begin
        bin_val = '0;
        bin_ovf = 1'b0;
        case (r_op) inside
            OP_ADD: begin
                bin_val = sum;
                bin_ovf = (r_rd_a[DATA_W-1] == r_rd_b[DATA_W-1])
                          && (sum[DATA_W-1] != r_rd_a[DATA_W-1]);
            end
            OP_SUB: begin
                bin_val = dif;
                bin_ovf = (r_rd_a[DATA_W-1] != r_rd_b[DATA_W-1])
                          && (dif[DATA_W-1] != r_rd_a[DATA_W-1]);
            end
            OP_EQ: bin_val = DATA_W'(r_rd_a == r_rd_b);
            OP_LT: bin_val = DATA_W'($signed(r_rd_a) < $signed(r_rd_b));
            OP_GT: bin_val = DATA_W'($signed(r_rd_a) > $signed(r_rd_b));
            OP_LE: bin_val = DATA_W'($signed(r_rd_a) <= $signed(r_rd_b));
            OP_GE: bin_val = DATA_W'($signed(r_rd_a) >= $signed(r_rd_b));
            default: bin_val = '0;
        endcase
    end

    always_comb begin
        mul_lo  = neg_res ? (~mul_prod[DATA_W-1:0] + 1'b1) : mul_prod[DATA_W-1:0];
        mul_ovf = (mul_prod[PROD_W-1:DATA_W] != '0)
                  || (mul_prod[DATA_W-1:0] > (neg_res ? MIN_VAL : MAX_VAL));
        if (r_op == OP_DIV) begin
            div_val = neg_res ? (~div_quot + 1'b1) : div_quot;
            div_ovf = (r_rd_a == MIN_VAL) && (r_rd_b == '1);
        end else begin
            div_val = r_rd_a[DATA_W-1] ? (~div_rem + 1'b1) : div_rem;
            div_ovf = 1'b0;
        end
    end

    always_comb begin
        res           = '0;
        res.status    = ST_OK;
        res.count     = r_count;
        res.wr_addr   = addr_a;
        res_ready     = 1'b0;
        mul_req.start = 1'b0;
        div_req.start = 1'b0;
        n_state       = r_state;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                res_ready = 1'b1;
                unique case (r_op) inside
                    OP_PUSH: begin
                        if (r_count >= CNT_W'(STACK_DEPTH)) begin
                            res.status = ST_OVER;
                        end else begin
                            res.wr_en   = 1'b1;
                            res.wr_addr = r_count[ADDR_W-1:0];
                            res.wr_data = r_imm;
                            res.count   = r_count + 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_EQ, OP_LT, OP_GT, OP_LE, OP_GE: begin
                        if (r_count < CNT_W'(2)) begin
                            res.status = ST_UNDER;
                        end else begin
                            res.status  = bin_ovf ? ST_OVER : ST_OK;
                            res.wr_en   = 1'b1;
                            res.wr_data = bin_val;
                            res.count   = r_count - 1'b1;
                        end
                    end
                    OP_MUL: begin
                        if (r_count < CNT_W'(2)) begin
                            res.status = ST_UNDER;
                        end else begin
                            res_ready     = 1'b0;
                            mul_req.start = 1'b1;
                        end
                    end
                    OP_DIV, OP_MOD: begin
                        if (r_count < CNT_W'(2)) begin
                            res.status = ST_UNDER;
                        end else if (r_rd_b == '0) begin
                            res.status = ST_DIVZ;
                        end else begin
                            res_ready     = 1'b0;
                            div_req.start = 1'b1;
                        end
                    end
                    OP_JUMP: begin
                        res.taken  = 1'b1;
                        res.target = r_imm[TGT_W-1:0];
                    end
                    OP_JZ: begin
                        if (r_count == '0) begin
                            res.status = ST_FATAL;
                        end else begin
                            res.count = r_count - 1'b1;
                            if (r_rd_b == '0) begin
                                res.taken  = 1'b1;
                                res.target = r_imm[TGT_W-1:0];
                            end
                        end
                    end
                    OP_PRINT: begin
                        if (r_count == '0) begin
                            res.status = ST_UNDER;
                        end else begin
                            res.count  = r_count - 1'b1;
                            res.pvalid = 1'b1;
                            res.pval   = r_rd_b;
                        end
                    end
                    default: res.status = ST_OK;
                endcase
                if (mul_req.start) begin
                    n_state = S_MUL;
                end else if (div_req.start) begin
                    n_state = S_DIV;
                end else begin
                    n_state = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_MUL: begin
                res.status  = mul_ovf ? ST_OVER : ST_OK;
                res.wr_en   = 1'b1;
                res.wr_data = mul_lo;
                res.count   = r_count - 1'b1;
                res_ready   = mul_sts.done;
                if (mul_sts.done) begin
                    n_state = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_DIV: begin
                res.status  = div_ovf ? ST_OVER : ST_OK;
                res.wr_en   = 1'b1;
                res.wr_data = div_val;
                res.count   = r_count - 1'b1;
                res_ready   = div_sts.done;
                if (div_sts.done) begin
                    n_state = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                res       = r_hold;
                res_ready = 1'b1;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_count   <= res.count;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= t_op'(s_axis_tuser);
            r_imm <= s_axis_tdata;
        end
        if (res_ready && !out_free && r_state != S_HOLD) begin
            r_hold <= res;
        end
        if (commit) begin
            r_m_data <= {{(OUT_W-OUT_USED_W){1'b0}}, DEPTH_W'(res.count), res.pval,
                         res.pvalid, res.target, res.taken, res.status};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_sts.busy || div_sts.busy) |-> !s_axis_tready)
        else $error("item accepted while an arithmetic unit is busy");

    a_depth_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_data[DEPTH_LSB +: DEPTH_W] == DEPTH_W'(r_count)))
        else $error("reported depth differs from stack count");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_sts.busy && div_sts.busy))
        else $error("multiplier and divider busy together");

endmodule

`default_nettype wire

>>> rtl/core/ose_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module ose_mul (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire ose_pkg::t_unit_req    i_req,
    input  wire [ose_pkg::DATA_W-1:0]  i_a,
    input  wire [ose_pkg::DATA_W-1:0]  i_b,
    output ose_pkg::t_unit_sts         o_sts,
    output logic [ose_pkg::PROD_W-1:0] o_prod
);
    import ose_pkg::*;

    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [2:0]        r_step;
    logic              r_busy;
    logic              r_done;
    logic [DATA_W-1:0] r_pp;
    logic [1:0]        r_sel;
    logic              r_pp_vld;
    logic [PROD_W-1:0] r_acc;

    logic [HALF_W-1:0] a_half;
    logic [HALF_W-1:0] b_half;
    logic [PROD_W-1:0] pp_aligned;

    always_comb begin
        a_half = r_step[0] ? r_a[DATA_W-1:HALF_W] : r_a[HALF_W-1:0];
        b_half = r_step[1] ? r_b[DATA_W-1:HALF_W] : r_b[HALF_W-1:0];
    end

    always_comb begin
        case ({1'b0, r_sel[0]} + {1'b0, r_sel[1]})
            2'd0:    pp_aligned = {{DATA_W{1'b0}}, r_pp};
            2'd1:    pp_aligned = {{HALF_W{1'b0}}, r_pp, {HALF_W{1'b0}}};
            default: pp_aligned = {r_pp, {DATA_W{1'b0}}};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_pp_vld <= 1'b0;
            r_step   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_step   <= '0;
                r_pp_vld <= 1'b0;
            end else if (r_busy) begin
                r_step   <= r_step + 3'd1;
                r_pp_vld <= (r_step != 3'd4);
                if (r_step == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_pp  <= a_half * b_half;
            r_sel <= r_step[1:0];
            if (r_pp_vld) begin
                r_acc <= r_acc + pp_aligned;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule

`default_nettype wire

>>> rtl/core/ose_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ose_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire ose_pkg::t_unit_req    i_req,
    input  wire [ose_pkg::DATA_W-1:0]  i_dividend,
    input  wire [ose_pkg::DATA_W-1:0]  i_divisor,
    output ose_pkg::t_unit_sts         o_sts,
    output logic [ose_pkg::DATA_W-1:0] o_quot,
    output logic [ose_pkg::DATA_W-1:0] o_rem
);
    import ose_pkg::*;

    localparam int ITER_W = $clog2(DATA_W);

    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_dvs;
    logic [ITER_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;

    always_comb begin
        rem_sh = {r_rem, r_quo[DATA_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ITER_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[DATA_W]) begin
                r_rem <= diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quo;
    assign o_rem      = r_rem;

endmodule

`default_nettype wire
